// ----- rtl/arce_pkg.sv -----
`timescale 1ns / 1ps
package arce_pkg;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SEG_BYTES = 40;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FORMAT_MODE   = 3'd0;
  localparam cfg_idx_t CFG_EMPTY_HASH_W0 = 3'd1;
  localparam cfg_idx_t CFG_EMPTY_HASH_W1 = 3'd2;
  localparam cfg_idx_t CFG_EMPTY_HASH_W2 = 3'd3;
  localparam cfg_idx_t CFG_EMPTY_HASH_W3 = 3'd4;

  localparam logic FMT_MASK  = 1'b0;
  localparam logic FMT_FIXED = 1'b1;

  // one field as it goes on the wire: length byte first, then the value bytes
  typedef logic [SEG_BYTES*8-1:0] seg_t;
  typedef logic [5:0]             seg_len_t;
  typedef logic [2:0]             slot_idx_t;

  typedef struct packed {
    seg_t     [NUM_SLOTS-1:0] data;
    seg_len_t [NUM_SLOTS-1:0] len;
    slot_idx_t                last_slot;
  } arce_entry_t;

  // number of bytes left once leading zero bytes are stripped
  function automatic logic [5:0] byte_len(input logic [255:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[8*i +: 8] != 8'h00) n = 6'(i + 1);
    end
    return n;
  endfunction

  // length byte followed by the low n bytes of v, most significant first
  function automatic seg_t make_seg(input logic [255:0] v, input logic [5:0] n);
    logic [255:0] norm;
    seg_t         s;
    norm = v << {(6'd32 - n), 3'b000};
    s = '0;
    s[7:0] = {2'b00, n};
    for (int j = 0; j < 32; j++) begin
      s[8*(j+1) +: 8] = norm[8*(31-j) +: 8];
    end
    return s;
  endfunction

endpackage

// ----- rtl/arce_front.sv -----
`timescale 1ns / 1ps
module arce_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  arce_pkg::cfg_idx_t    cfg_index,
  input  logic [63:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_nonce,
  input  logic [63:0]           in_balance_w0,
  input  logic [63:0]           in_balance_w1,
  input  logic [63:0]           in_balance_w2,
  input  logic [63:0]           in_balance_w3,
  input  logic [63:0]           in_incarnation,
  input  logic [63:0]           in_contract_hash_w0,
  input  logic [63:0]           in_contract_hash_w1,
  input  logic [63:0]           in_contract_hash_w2,
  input  logic [63:0]           in_contract_hash_w3,
  input  logic                  in_omit_hash,
  input  logic                  fifo_full,
  output logic                  push,
  output arce_pkg::arce_entry_t push_entry
);

  logic        format_mode_r;
  logic [63:0] empty_hash_r [4];

  logic         a_valid_r;
  logic         a_fmt_r;
  logic [63:0]  a_nonce_r;
  logic [255:0] a_bal_r;
  logic [63:0]  a_inc_r;
  logic [255:0] a_hash_r;
  logic [3:0]   a_nlen_r;
  logic [5:0]   a_blen_r;
  logic [3:0]   a_ilen_r;
  logic         a_hash_empty_r;
  logic         a_hash_on_r;

  logic         accept;
  logic [255:0] bal_in;
  logic [255:0] hash_in;
  logic         hash_empty;

  arce_pkg::seg_t nseg, bseg, iseg, hseg, eseg, mseg;
  logic [5:0]     nlen6, ilen6;
  logic [7:0]     mask;

  assign in_ready = !a_valid_r || !fifo_full;
  assign accept   = in_valid && in_ready;
  assign push     = a_valid_r && !fifo_full;

  assign bal_in  = {in_balance_w3, in_balance_w2, in_balance_w1, in_balance_w0};
  assign hash_in = {in_contract_hash_w3, in_contract_hash_w2, in_contract_hash_w1,
                    in_contract_hash_w0};
  assign hash_empty = (in_contract_hash_w0 == empty_hash_r[0]) &&
                      (in_contract_hash_w1 == empty_hash_r[1]) &&
                      (in_contract_hash_w2 == empty_hash_r[2]) &&
                      (in_contract_hash_w3 == empty_hash_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= 1'b0;
      for (int k = 0; k < 4; k++) empty_hash_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arce_pkg::CFG_FORMAT_MODE:   format_mode_r   <= cfg_wdata[0];
        arce_pkg::CFG_EMPTY_HASH_W0: empty_hash_r[0] <= cfg_wdata;
        arce_pkg::CFG_EMPTY_HASH_W1: empty_hash_r[1] <= cfg_wdata;
        arce_pkg::CFG_EMPTY_HASH_W2: empty_hash_r[2] <= cfg_wdata;
        arce_pkg::CFG_EMPTY_HASH_W3: empty_hash_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classify stage: byte lengths and hash match are registered with the record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (push) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_fmt_r        <= format_mode_r;
      a_nonce_r      <= in_nonce;
      a_bal_r        <= bal_in;
      a_inc_r        <= in_incarnation;
      a_hash_r       <= hash_in;
      a_nlen_r       <= 4'(arce_pkg::byte_len({192'b0, in_nonce}));
      a_blen_r       <= arce_pkg::byte_len(bal_in);
      a_ilen_r       <= 4'(arce_pkg::byte_len({192'b0, in_incarnation}));
      a_hash_empty_r <= hash_empty;
      a_hash_on_r    <= !hash_empty && !in_omit_hash;
    end
  end

  assign nlen6 = {2'b00, a_nlen_r};
  assign ilen6 = {2'b00, a_ilen_r};
  assign mask  = {4'b0000, a_hash_on_r, (a_ilen_r != 4'd0), (a_blen_r != 6'd0),
                  (a_nlen_r != 4'd0)};

  always_comb begin
    nseg = arce_pkg::make_seg({192'b0, a_nonce_r}, nlen6);
    bseg = arce_pkg::make_seg(a_bal_r, a_blen_r);
    iseg = arce_pkg::make_seg({192'b0, a_inc_r}, ilen6);
    hseg = arce_pkg::make_seg(a_hash_r, 6'd32);
    eseg = arce_pkg::make_seg('0, 6'd0);
    mseg = '0;
    mseg[7:0] = mask;
  end

  always_comb begin
    push_entry = '0;
    unique case (a_fmt_r)
      arce_pkg::FMT_MASK: begin
        push_entry.data[0] = mseg;
        push_entry.data[1] = nseg;
        push_entry.data[2] = bseg;
        push_entry.data[3] = iseg;
        push_entry.data[4] = hseg;
        push_entry.len[0]  = 6'd1;
        push_entry.len[1]  = mask[0] ? nlen6 + 6'd1 : 6'd0;
        push_entry.len[2]  = mask[1] ? a_blen_r + 6'd1 : 6'd0;
        push_entry.len[3]  = mask[2] ? ilen6 + 6'd1 : 6'd0;
        push_entry.len[4]  = mask[3] ? 6'd33 : 6'd0;
        priority if (mask[3]) push_entry.last_slot = 3'd4;
        else if (mask[2])     push_entry.last_slot = 3'd3;
        else if (mask[1])     push_entry.last_slot = 3'd2;
        else if (mask[0])     push_entry.last_slot = 3'd1;
        else                  push_entry.last_slot = 3'd0;
      end
      arce_pkg::FMT_FIXED: begin
        push_entry.data[0] = nseg;
        push_entry.data[1] = bseg;
        push_entry.data[2] = a_hash_empty_r ? eseg : hseg;
        push_entry.data[3] = iseg;
        push_entry.data[4] = '0;
        push_entry.len[0]  = nlen6 + 6'd1;
        push_entry.len[1]  = a_blen_r + 6'd1;
        push_entry.len[2]  = a_hash_empty_r ? 6'd1 : 6'd33;
        push_entry.len[3]  = ilen6 + 6'd1;
        push_entry.len[4]  = 6'd0;
        push_entry.last_slot = 3'd3;
      end
      default: push_entry = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_first_field_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_entry.len[0] != 6'd0)
    else $error("first field of a record is empty");

  a_last_field_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_entry.len[push_entry.last_slot] != 6'd0)
    else $error("last field of a record is empty");

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> a_valid_r)
    else $error("accepted record not held in classify stage");
`endif

endmodule

// ----- rtl/arce_fifo.sv -----
`timescale 1ns / 1ps
module arce_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  arce_pkg::arce_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output arce_pkg::arce_entry_t head
);

  arce_pkg::arce_entry_t mem_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/arce_back.sv -----
`timescale 1ns / 1ps
module arce_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  arce_pkg::arce_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_chunk_bytes,
  output logic [3:0]            out_chunk_count,
  output logic                  out_last_chunk
);

  logic [119:0]        acc_r, acc_nxt;
  logic [3:0]          acc_cnt_r, acc_cnt_nxt;
  arce_pkg::slot_idx_t slot_r, slot_nxt;
  logic [2:0]          piece_r, piece_nxt;
  logic                drain_r, drain_nxt;

  logic                out_valid_r;
  logic [63:0]         out_bytes_r;
  logic [3:0]          out_count_r;
  logic                out_last_r;

  logic                out_free;
  arce_pkg::seg_len_t  slot_len;
  arce_pkg::seg_t      slot_data;
  logic [5:0]          rem;
  logic                last_piece;
  logic [3:0]          take;
  logic [63:0]         piece_bytes;
  logic [119:0]        base;
  logic [3:0]          cnt_base;
  logic                emit_now;
  logic                emit_last;
  logic [3:0]          emit_cnt;

  assign out_free    = !out_valid_r || out_ready;
  assign slot_len    = head.len[slot_r];
  assign slot_data   = head.data[slot_r];
  assign rem         = slot_len - {piece_r, 3'b000};
  assign last_piece  = (rem <= 6'd8);
  assign take        = last_piece ? rem[3:0] : 4'd8;
  assign piece_bytes = slot_data[{piece_r, 6'b000000} +: 64];

  always_comb begin
    acc_nxt     = acc_r;
    acc_cnt_nxt = acc_cnt_r;
    slot_nxt    = slot_r;
    piece_nxt   = piece_r;
    drain_nxt   = drain_r;
    pop         = 1'b0;
    emit_now    = 1'b0;
    emit_last   = 1'b0;
    emit_cnt    = 4'd8;
    base        = acc_r;
    cnt_base    = acc_cnt_r;
    if (drain_r) begin
      // record fully packed, flush what is left
      if (out_free) begin
        emit_now = 1'b1;
        if (acc_cnt_r > 4'd8) begin
          acc_nxt     = acc_r >> 64;
          acc_cnt_nxt = acc_cnt_r - 4'd8;
        end else begin
          emit_last   = 1'b1;
          emit_cnt    = acc_cnt_r;
          acc_nxt     = '0;
          acc_cnt_nxt = 4'd0;
          drain_nxt   = 1'b0;
        end
      end
    end else begin
      emit_now = acc_cnt_r[3] && out_free;
      if (emit_now) begin
        base     = acc_r >> 64;
        cnt_base = acc_cnt_r - 4'd8;
      end
      acc_nxt     = base;
      acc_cnt_nxt = cnt_base;
      // append up to eight bytes of the current field behind what is held
      if (head_valid && !cnt_base[3]) begin
        acc_nxt     = base | ({56'b0, piece_bytes} << {cnt_base[2:0], 3'b000});
        acc_cnt_nxt = cnt_base + take;
        if (last_piece) begin
          piece_nxt = 3'd0;
          if (slot_r == head.last_slot) begin
            slot_nxt  = '0;
            drain_nxt = 1'b1;
            pop       = 1'b1;
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
        end else begin
          piece_nxt = piece_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      acc_cnt_r   <= 4'd0;
      slot_r      <= '0;
      piece_r     <= 3'd0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      slot_r    <= slot_nxt;
      piece_r   <= piece_nxt;
      drain_r   <= drain_nxt;
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_bytes_r <= acc_r[63:0];
      out_count_r <= emit_cnt;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chunk_bytes = out_bytes_r;
  assign out_chunk_count = out_count_r;
  assign out_last_chunk  = out_last_r;

`ifndef NO_ASSERTIONS
  a_drain_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> acc_cnt_r != 4'd0)
    else $error("flush with nothing held");

  a_full_inner_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> out_count_r == 4'd8)
    else $error("chunk before the last one is not full");

  a_pop_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> drain_r)
    else $error("record released without flush");
`endif

endmodule

// ----- rtl/account_record_compact_encoder.sv -----
`timescale 1ns / 1ps
// Account record compact encoder. Each accepted record is classified and
// stripped of leading zero bytes in a one-stage front end, then parked in a
// two-entry queue, so a new record is taken while the serializer still packs
// earlier ones and while a finished chunk waits at the output register. The
// serializer packs one field piece of up to eight bytes per cycle (length
// byte included), unless its 15-byte holding register already holds a beat
// and the output is busy or a flush runs, and emits 8-byte beats. It steps
// through every started 8-byte piece of each field up to the last present
// one, passing once over each absent field before it, then flushes the tail.
// The user must write the empty-code hash and format through the cfg port
// only while no record is in flight; the block does not enforce this.
module account_record_compact_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  arce_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_nonce,
  input  logic [63:0]        in_balance_w0,
  input  logic [63:0]        in_balance_w1,
  input  logic [63:0]        in_balance_w2,
  input  logic [63:0]        in_balance_w3,
  input  logic [63:0]        in_incarnation,
  input  logic [63:0]        in_contract_hash_w0,
  input  logic [63:0]        in_contract_hash_w1,
  input  logic [63:0]        in_contract_hash_w2,
  input  logic [63:0]        in_contract_hash_w3,
  input  logic               in_omit_hash,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_chunk_bytes,
  output logic [3:0]         out_chunk_count,
  output logic               out_last_chunk
);

  logic                  push;
  logic                  fifo_full;
  arce_pkg::arce_entry_t push_entry;
  logic                  pop;
  logic                  head_valid;
  arce_pkg::arce_entry_t head;

  arce_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_nonce            (in_nonce),
    .in_balance_w0       (in_balance_w0),
    .in_balance_w1       (in_balance_w1),
    .in_balance_w2       (in_balance_w2),
    .in_balance_w3       (in_balance_w3),
    .in_incarnation      (in_incarnation),
    .in_contract_hash_w0 (in_contract_hash_w0),
    .in_contract_hash_w1 (in_contract_hash_w1),
    .in_contract_hash_w2 (in_contract_hash_w2),
    .in_contract_hash_w3 (in_contract_hash_w3),
    .in_omit_hash        (in_omit_hash),
    .fifo_full           (fifo_full),
    .push                (push),
    .push_entry          (push_entry)
  );

  arce_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  arce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_chunk_bytes (out_chunk_bytes),
    .out_chunk_count (out_chunk_count),
    .out_last_chunk  (out_last_chunk)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned NUM_CFG_REGS = 5;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned PHASE_ITEMS  = 45;
  localparam int unsigned DRAIN_CYCLES = 40;

  // presence-mask bits of format 0
  localparam logic [7:0] HAS_NONCE       = 8'h01;
  localparam logic [7:0] HAS_BALANCE     = 8'h02;
  localparam logic [7:0] HAS_INCARNATION = 8'h04;
  localparam logic [7:0] HAS_HASH        = 8'h08;
  localparam logic [7:0] HASH_LEN        = 8'd32;

  typedef struct packed {
    logic [63:0]      nonce;
    logic [3:0][63:0] balance;
    logic [63:0]      incarnation;
    logic [3:0][63:0] contract_hash;
    logic             omit_hash;
  } record_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } chunk_t;

  typedef struct packed {
    logic    fmt;
    record_t rec;
    logic    typed;
    chunk_t  known;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  arce_pkg::cfg_idx_t cfg_index;
  logic [63:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [63:0]        in_nonce;
  logic [63:0]        in_balance_w0, in_balance_w1, in_balance_w2, in_balance_w3;
  logic [63:0]        in_incarnation;
  logic [63:0]        in_contract_hash_w0, in_contract_hash_w1;
  logic [63:0]        in_contract_hash_w2, in_contract_hash_w3;
  logic               in_omit_hash;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [63:0]        out_chunk_bytes;
  logic [3:0]         out_chunk_count;
  logic               out_last_chunk;

  // shadow of the block's registers
  logic             fmt_now;
  logic [3:0][63:0] empty_hash;

  logic [7:0]  record_bytes[$];
  chunk_t      expected_chunks[$];
  chunk_t      want_chunk;
  stim_row_t   stim_table[$];
  record_t     cur_rec;
  bit          no_idle;
  int unsigned faults;
  int unsigned records_sent;
  int unsigned chunks_seen;

  account_record_compact_encoder uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_nonce            (in_nonce),
    .in_balance_w0       (in_balance_w0),
    .in_balance_w1       (in_balance_w1),
    .in_balance_w2       (in_balance_w2),
    .in_balance_w3       (in_balance_w3),
    .in_incarnation      (in_incarnation),
    .in_contract_hash_w0 (in_contract_hash_w0),
    .in_contract_hash_w1 (in_contract_hash_w1),
    .in_contract_hash_w2 (in_contract_hash_w2),
    .in_contract_hash_w3 (in_contract_hash_w3),
    .in_omit_hash        (in_omit_hash),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_chunk_bytes     (out_chunk_bytes),
    .out_chunk_count     (out_chunk_count),
    .out_last_chunk      (out_last_chunk)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void add_byte(input logic [7:0] b);
    record_bytes.insert(record_bytes.size(), b);
  endfunction

  function automatic void add_chunk(input chunk_t c);
    expected_chunks.insert(expected_chunks.size(), c);
  endfunction

  function automatic void add_row(input stim_row_t s);
    stim_table.insert(stim_table.size(), s);
  endfunction

  // length byte, then the value big-endian with leading zero bytes dropped
  function automatic void push_stripped(input logic [255:0] v);
    int n;
    n = 0;
    for (int i = 31; i >= 0; i--) begin
      if (n == 0 && v[8*i +: 8] != 8'h00) n = i + 1;
    end
    add_byte(8'(n));
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_full_hash(input logic [255:0] h);
    add_byte(HASH_LEN);
    for (int i = 31; i >= 0; i--) add_byte(h[8*i +: 8]);
  endfunction

  function automatic void predict_chunks(input record_t r);
    logic [7:0] mask;
    logic       hash_empty;
    chunk_t     c;
    int         left;
    record_bytes.delete();
    hash_empty = (r.contract_hash == empty_hash);
    if (fmt_now == arce_pkg::FMT_MASK) begin
      mask = '0;
      add_byte(8'h00);
      if (r.nonce != '0) begin
        mask |= HAS_NONCE;
        push_stripped(256'(r.nonce));
      end
      if (r.balance != '0) begin
        mask |= HAS_BALANCE;
        push_stripped(r.balance);
      end
      if (r.incarnation != '0) begin
        mask |= HAS_INCARNATION;
        push_stripped(256'(r.incarnation));
      end
      if (!hash_empty && !r.omit_hash) begin
        mask |= HAS_HASH;
        push_full_hash(r.contract_hash);
      end
      record_bytes[0] = mask;
    end else begin
      push_stripped(256'(r.nonce));
      push_stripped(r.balance);
      if (hash_empty) add_byte(8'h00);
      else push_full_hash(r.contract_hash);
      push_stripped(256'(r.incarnation));
    end
    for (int k = 0; k < record_bytes.size(); k += 8) begin
      left = record_bytes.size() - k;
      c.bytes = '0;
      c.count = 4'((left > 8) ? 8 : left);
      for (int p = 0; p < c.count; p++) c.bytes[8*p +: 8] = record_bytes[k + p];
      c.last = (left <= 8);
      add_chunk(c);
    end
  endfunction

  // zero, all ones, or a random value of random byte length
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    int unsigned nb;
    w = {$urandom, $urandom};
    nb = $urandom_range(8);
    case ($urandom_range(5))
      0: w = '0;
      1: w = '1;
      default: w = (nb == 0) ? 64'h0 : w >> (8 * (8 - nb));
    endcase
    return w;
  endfunction

  function automatic record_t random_record();
    record_t r;
    int      j;
    int      b;
    r.nonce = rand_word();
    for (int i = 0; i < 4; i++) r.balance[i] = rand_word();
    if ($urandom_range(4) == 0) r.balance = '0;
    r.incarnation = rand_word();
    j = $urandom_range(3);
    b = $urandom_range(63);
    case ($urandom_range(9))
      0, 1, 2: r.contract_hash = empty_hash;
      3: begin
        // one bit away from the empty-code hash
        r.contract_hash = empty_hash;
        r.contract_hash[j][b] = ~r.contract_hash[j][b];
      end
      4: r.contract_hash = '0;
      default: begin
        for (int i = 0; i < 4; i++) r.contract_hash[i] = {$urandom, $urandom};
      end
    endcase
    r.omit_hash = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic stim_row_t row(input logic fmt, input logic [63:0] nonce,
                                    input logic [255:0] bal, input logic [63:0] inc,
                                    input logic [255:0] hash, input logic omit,
                                    input logic typed, input logic [63:0] exp_bytes,
                                    input logic [3:0] exp_count);
    stim_row_t s;
    s.fmt               = fmt;
    s.rec.nonce         = nonce;
    s.rec.balance       = bal;
    s.rec.incarnation   = inc;
    s.rec.contract_hash = hash;
    s.rec.omit_hash     = omit;
    s.typed             = typed;
    s.known.bytes       = exp_bytes;
    s.known.count       = exp_count;
    s.known.last        = 1'b1;
    return s;
  endfunction

  task automatic write_reg(input arce_pkg::cfg_idx_t idx, input logic [63:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      arce_pkg::CFG_FORMAT_MODE:   fmt_now = data[0];
      arce_pkg::CFG_EMPTY_HASH_W0: empty_hash[0] = data;
      arce_pkg::CFG_EMPTY_HASH_W1: empty_hash[1] = data;
      arce_pkg::CFG_EMPTY_HASH_W2: empty_hash[2] = data;
      arce_pkg::CFG_EMPTY_HASH_W3: empty_hash[3] = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_chunks.size() != 0) @(negedge clk);
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_record(input record_t r);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_nonce            = r.nonce;
    in_balance_w0       = r.balance[0];
    in_balance_w1       = r.balance[1];
    in_balance_w2       = r.balance[2];
    in_balance_w3       = r.balance[3];
    in_incarnation      = r.incarnation;
    in_contract_hash_w0 = r.contract_hash[0];
    in_contract_hash_w1 = r.contract_hash[1];
    in_contract_hash_w2 = r.contract_hash[2];
    in_contract_hash_w3 = r.contract_hash[3];
    in_omit_hash        = r.omit_hash;
    in_valid            = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    records_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      chunks_seen++;
      if (expected_chunks.size() == 0) begin
        faults++;
        $display("%0t: chunk with nothing expected: bytes %h count %0d last %0b",
                 $time, out_chunk_bytes, out_chunk_count, out_last_chunk);
      end else begin
        want_chunk = expected_chunks.pop_front();
        if (out_chunk_bytes !== want_chunk.bytes) begin
          faults++;
          $display("%0t: chunk_bytes expected %h got %h",
                   $time, want_chunk.bytes, out_chunk_bytes);
        end
        if (out_chunk_count !== want_chunk.count) begin
          faults++;
          $display("%0t: chunk_count expected %0d got %0d",
                   $time, want_chunk.count, out_chunk_count);
        end
        if (out_last_chunk !== want_chunk.last) begin
          faults++;
          $display("%0t: last_chunk expected %0b got %0b",
                   $time, want_chunk.last, out_last_chunk);
        end
      end
    end
  end

  initial begin
    #500000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = arce_pkg::CFG_FORMAT_MODE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_nonce = '0;
    in_balance_w0 = '0;
    in_balance_w1 = '0;
    in_balance_w2 = '0;
    in_balance_w3 = '0;
    in_incarnation = '0;
    in_contract_hash_w0 = '0;
    in_contract_hash_w1 = '0;
    in_contract_hash_w2 = '0;
    in_contract_hash_w3 = '0;
    in_omit_hash = 1'b0;
    fmt_now = arce_pkg::FMT_MASK;
    empty_hash = '0;
    no_idle = 1'b0;
    faults = 0;
    records_sent = 0;
    chunks_seen = 0;

    // format 0 rows run on the reset registers, empty-code hash all zero
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'd0, 64'd0, 256'd0, 1'b0, 1'b1,
                64'h0, 4'd1));
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'd0, 64'd0, 256'd0, 1'b1, 1'b1,
                64'h0, 4'd1));
    add_row(row(arce_pkg::FMT_MASK, 64'd1, 256'd0, 64'd0, 256'd0, 1'b0, 1'b1,
                64'h01_01_01, 4'd3));
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'd1, 64'd0, 256'd0, 1'b0, 1'b1,
                64'h01_01_02, 4'd3));
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'd0, 64'd1, 256'd0, 1'b1, 1'b1,
                64'h01_01_04, 4'd3));
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'd0, 64'd0, 256'd1, 1'b0, 1'b0,
                64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, '1, '1, '1, '1, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, '1, '1, '1, '1, 1'b1, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, '1, 256'd0, 64'd0, 256'd0, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, 64'd0, 256'h80 << 248, 64'h8000_0000_0000_0000,
                256'd0, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, 64'h100, 256'h1_0000, 64'h1_0000_0000, 256'd0,
                1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, {4{16'hAAAA}}, {16{16'hAAAA}}, {4{16'hAAAA}},
                {16{16'hAAAA}}, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_MASK, {4{16'h5555}}, {16{16'h5555}}, {4{16'h5555}},
                {16{16'h5555}}, 1'b1, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, 64'd0, 256'd0, 64'd0, 256'd0, 1'b0, 1'b1,
                64'h0, 4'd4));
    add_row(row(arce_pkg::FMT_FIXED, 64'd0, 256'd0, 64'd0, 256'd0, 1'b1, 1'b1,
                64'h0, 4'd4));
    add_row(row(arce_pkg::FMT_FIXED, 64'd1, 256'd0, 64'd0, 256'd0, 1'b0, 1'b1,
                64'h01_01, 4'd5));
    add_row(row(arce_pkg::FMT_FIXED, 64'd0, 256'd0, 64'd1, 256'd0, 1'b0, 1'b1,
                64'h01_01_00_00_00, 4'd5));
    add_row(row(arce_pkg::FMT_FIXED, 64'd0, 256'd0, 64'd0, 256'd1, 1'b0, 1'b0,
                64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, '1, '1, '1, '1, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, '1, '1, '1, '1, 1'b1, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, 64'h8000_0000_0000_0000, 256'h80 << 248, 64'd0,
                256'd0, 1'b1, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, {4{16'hAAAA}}, {16{16'h5555}}, {4{16'hAAAA}},
                {16{16'h5555}}, 1'b0, 1'b0, 64'h0, 4'd0));
    add_row(row(arce_pkg::FMT_FIXED, {4{16'h5555}}, {16{16'hAAAA}}, {4{16'h5555}},
                {16{16'hAAAA}}, 1'b1, 1'b0, 64'h0, 4'd0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].fmt != fmt_now) begin
        wait_idle();
        write_reg(arce_pkg::CFG_FORMAT_MODE, 64'(stim_table[i].fmt));
      end
      send_record(stim_table[i].rec);
      if (stim_table[i].typed) add_chunk(stim_table[i].known);
      else predict_chunks(stim_table[i].rec);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      // upper bits of the format word are don't-care
      write_reg(arce_pkg::CFG_FORMAT_MODE,
                {$urandom, 31'($urandom),
                 (p % 2 == 1) ? arce_pkg::FMT_FIXED : arce_pkg::FMT_MASK});
      for (int w = 0; w < 4; w++) begin
        write_reg(arce_pkg::cfg_idx_t'(arce_pkg::CFG_EMPTY_HASH_W0 + w),
                  (p == 0) ? 64'h0 : (p == 1 || p == 4) ? '1 : {$urandom, $urandom});
      end
      // an index past the register list must change nothing
      write_reg(arce_pkg::cfg_idx_t'(NUM_CFG_REGS + $urandom_range(2)),
                {$urandom, $urandom});
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cur_rec = random_record();
        send_record(cur_rec);
        predict_chunks(cur_rec);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d records sent in both formats over %0d register settings", records_sent,
             NUM_PHASES + 2);
    $display("%0d output beats checked, %0d mismatches", chunks_seen, faults);
    if (faults == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
